// File: design/tcq_pkg.sv
// shared types, widths and defaults for the timed command queue
// no dependencies
`default_nettype none
package tcq_pkg;
    localparam int DEF_CLIENTS = 8;
    localparam int DEF_DEPTH   = 16;
    localparam int OP_W        = 2;
    localparam int CLIENT_W    = 3;
    localparam int CMD_W       = 8;
    localparam int TIME_W      = 32;
    localparam int DATA_W      = 32;
    localparam int TEXT_W      = 16;
    localparam int QCNT_W      = 5;
    localparam int LIMIT_W     = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_FETCH  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] deadline;
        logic [DATA_W-1:0] payload;
        logic [TEXT_W-1:0] text;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic rd;
        logic ev;
        logic fin;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_scan;
        logic scan_done;
        logic out_free;
    } t_ctl_sts;
endpackage
`default_nettype wire

// File: design/tcq_if.sv
// request and response channel interfaces
// depends on tcq_pkg
`default_nettype none
interface tcq_req_if;
    logic                           valid;
    logic                           ready;
    logic [tcq_pkg::OP_W-1:0]       op;
    logic [tcq_pkg::CLIENT_W-1:0]   client;
    logic [tcq_pkg::CMD_W-1:0]      command;
    logic [tcq_pkg::TIME_W-1:0]     delay;
    logic [tcq_pkg::DATA_W-1:0]     payload;
    logic [tcq_pkg::TEXT_W-1:0]     text_ref;
    logic [tcq_pkg::TIME_W-1:0]     now;
    modport source (output valid, op, client, command, delay, payload, text_ref, now,
                    input ready);
    modport sink   (input valid, op, client, command, delay, payload, text_ref, now,
                    output ready);
endinterface

interface tcq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [tcq_pkg::CMD_W-1:0]      out_command;
    logic [tcq_pkg::DATA_W-1:0]     out_payload;
    logic [tcq_pkg::TEXT_W-1:0]     out_text_ref;
    logic                           kicked;
    logic [tcq_pkg::QCNT_W-1:0]     queue_count;
    logic                           overflow;
    modport source (output valid, found, out_command, out_payload, out_text_ref, kicked,
                    queue_count, overflow, input ready);
    modport sink   (input valid, found, out_command, out_payload, out_text_ref, kicked,
                    queue_count, overflow, output ready);
endinterface
`default_nettype wire

// File: design/timed_command_queue_unit.sv
// top level of the timed command queue: controller plus datapath
// depends on tcq_pkg, tcq_if, tcq_ctrl, tcq_datapath
//
//  channel   | dir | handshake       | carries
//  i_req     | in  | valid / ready   | op, client, command, delay, payload, text_ref, now
//  o_rsp     | out | valid / ready   | found, out_command/payload/text_ref, kicked, count, overflow
//  i_cfg_*   | in  | write enable    | safety limit, 5 bits
//
// add, clear and a request for an absent client: start step, then finish registers the result
// fetch and remove: start, then a read and an eval per stored entry, a last read, then finish
// the block is ready for the next request in the cycle after the result registers
// synchronous active-low reset clears counts and kicked flags, sets limit to 16; no clearing pass
// a stalled result holds the finish step until the output register frees
`default_nettype none
module timed_command_queue_unit #(
    parameter int CLIENTS = tcq_pkg::DEF_CLIENTS,
    parameter int DEPTH   = tcq_pkg::DEF_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [tcq_pkg::LIMIT_W-1:0] i_cfg_wdata,
    tcq_req_if.sink                          i_req,
    tcq_rsp_if.source                        o_rsp
);
    import tcq_pkg::*;

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;
    logic     ready;
    logic     accept;

    // request accepted when both sides agree
    assign accept      = i_req.valid && ready;
    assign i_req.ready = ready;

    // sequencer: idle, start, read/eval scan loop, finish
    tcq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sts    (ctl_sts),
        .o_ready  (ready),
        .o_cmd    (ctl_cmd)
    );

    // entry storage, compaction and result register
    tcq_datapath #(
        .CLIENTS (CLIENTS),
        .DEPTH   (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cmd       (ctl_cmd),
        .o_sts       (ctl_sts)
    );
endmodule
`default_nettype wire

// File: design/tcq_ctrl.sv
// controller state machine: sequences load, scan and finish
// depends on tcq_pkg
`default_nettype none
module tcq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire tcq_pkg::t_ctl_sts i_sts,
    output logic                   o_ready,
    output tcq_pkg::t_ctl_cmd      o_cmd
);
    import tcq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_accept) n_state = ST_START;
            ST_START:  n_state = i_sts.is_scan ? ST_READ : ST_FINISH;
            ST_READ:   n_state = i_sts.scan_done ? ST_FINISH : ST_EVAL;
            ST_EVAL:   n_state = ST_READ;
            ST_FINISH: if (i_sts.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.accept = i_accept;
        unique case (r_state)
            ST_IDLE:   o_ready = 1'b1;
            ST_START:  ;
            ST_READ:   o_cmd.rd = !i_sts.scan_done;
            ST_EVAL:   o_cmd.ev = 1'b1;
            ST_FINISH: o_cmd.fin = i_sts.out_free;
            default:   ;
        endcase
    end
endmodule
`default_nettype wire

// File: design/tcq_datapath.sv
// datapath: entry memory, per-client counts and flags, compaction, result register
// depends on tcq_pkg and tcq_if
`default_nettype none
module tcq_datapath #(
    parameter int CLIENTS = tcq_pkg::DEF_CLIENTS,
    parameter int DEPTH   = tcq_pkg::DEF_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [tcq_pkg::LIMIT_W-1:0] i_cfg_wdata,
    tcq_req_if.sink                         i_req,
    tcq_rsp_if.source                       o_rsp,
    input  wire tcq_pkg::t_ctl_cmd          i_cmd,
    output tcq_pkg::t_ctl_sts               o_sts
);
    import tcq_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CIW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int AW  = $clog2(CLIENTS * DEPTH);
    localparam int SLOTS = CLIENTS * DEPTH;

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    logic [LIMIT_W-1:0] r_limit;
    logic [CW-1:0]      r_count [CLIENTS];
    logic [CLIENTS-1:0] r_kicked;

    t_op               r_op;
    logic [CIW-1:0]    r_cl;
    logic              r_cl_ok;
    logic [CMD_W-1:0]  r_cmd;
    logic [TIME_W-1:0] r_dl;
    logic [TIME_W-1:0] r_now;
    logic [DATA_W-1:0] r_pay;
    logic [TEXT_W-1:0] r_text;
    logic [CW-1:0]     r_cnt;
    logic              r_kf;
    logic [CW-1:0]     r_rd;
    logic [CW-1:0]     r_wr;
    logic              r_found;
    t_entry            r_hit;

    logic              r_ov;
    logic              r_o_found;
    t_entry            r_o_hit;
    logic              r_o_kick;
    logic [QCNT_W-1:0] r_o_cnt;
    logic              r_o_over;

    logic [8:0]        cl_ext;
    logic [CIW-1:0]    cl_idx;
    logic [TIME_W:0]   dl_sum;
    logic [AW-1:0]     base;
    logic              del;
    logic              full;
    logic [CW-1:0]     fin_cnt;
    logic              set_kick;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    t_entry            mem_wd;

    assign cl_ext = {{(9 - CLIENT_W){1'b0}}, i_req.client};
    assign cl_idx = CIW'(cl_ext);
    assign dl_sum = {1'b0, i_req.now} + {1'b0, i_req.delay};
    assign base   = AW'(32'(r_cl) * 32'(DEPTH));
    assign full   = (32'(r_cnt) >= 32'(DEPTH));

    // entry to drop during a scan
    assign del = ((r_op == OP_FETCH) && !r_found && (r_rdata.deadline < r_now)) ||
                 ((r_op == OP_REMOVE) && (r_rdata.command == r_cmd));

    always_comb begin
        fin_cnt = r_cnt;
        case (r_op)
            OP_ADD:   fin_cnt = full ? r_cnt : r_cnt + CW'(1);
            OP_CLEAR: fin_cnt = '0;
            default:  fin_cnt = r_wr;
        endcase
    end

    assign set_kick = (r_op == OP_ADD) && !full && (32'(fin_cnt) >= 32'(r_limit));

    always_comb begin
        mem_we = 1'b0;
        mem_wa = base + AW'(r_wr);
        mem_wd = r_rdata;
        if (i_cmd.ev && !del) begin
            mem_we = 1'b1;
        end else if (i_cmd.fin && r_cl_ok && (r_op == OP_ADD) && !full) begin
            mem_we = 1'b1;
            mem_wa = base + AW'(r_cnt);
            mem_wd = '{command: r_cmd, deadline: r_dl, payload: r_pay, text: r_text};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (i_cmd.rd) r_rdata <= r_mem[base + AW'(r_rd)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= t_op'(i_req.op);
            r_cl    <= cl_idx;
            r_cl_ok <= (cl_ext < 9'(CLIENTS));
            r_cmd   <= i_req.command;
            r_dl    <= dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
            r_now   <= i_req.now;
            r_pay   <= i_req.payload;
            r_text  <= i_req.text_ref;
            r_cnt   <= r_count[cl_idx];
            r_kf    <= r_kicked[cl_idx];
            r_rd    <= '0;
            r_wr    <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.ev) begin
            r_rd <= r_rd + CW'(1);
            if (!del) r_wr <= r_wr + CW'(1);
            if (del && (r_op == OP_FETCH)) begin
                r_found <= 1'b1;
                r_hit   <= r_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_kicked <= '0;
            r_ov     <= 1'b0;
            for (int k = 0; k < CLIENTS; k++) r_count[k] <= '0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (i_cmd.fin) begin
                r_ov <= 1'b1;
                if (r_cl_ok) begin
                    r_count[r_cl] <= fin_cnt;
                    if (set_kick) r_kicked[r_cl] <= 1'b1;
                end
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_o_found <= r_cl_ok && r_found;
            r_o_hit   <= (r_cl_ok && r_found) ? r_hit : '0;
            r_o_kick  <= r_cl_ok && (r_kf || set_kick);
            r_o_cnt   <= r_cl_ok ? QCNT_W'(32'(fin_cnt)) : '0;
            r_o_over  <= r_cl_ok && (r_op == OP_ADD) && full;
        end
    end

    assign o_sts.is_scan   = r_cl_ok && ((r_op == OP_FETCH) || (r_op == OP_REMOVE));
    assign o_sts.scan_done = (r_rd == r_cnt);
    assign o_sts.out_free  = !r_ov || o_rsp.ready;

    assign o_rsp.valid        = r_ov;
    assign o_rsp.found        = r_o_found;
    assign o_rsp.out_command  = r_o_hit.command;
    assign o_rsp.out_payload  = r_o_hit.payload;
    assign o_rsp.out_text_ref = r_o_hit.text;
    assign o_rsp.kicked       = r_o_kick;
    assign o_rsp.queue_count  = r_o_cnt;
    assign o_rsp.overflow     = r_o_over;
endmodule
`default_nettype wire

// File: design/tcq_checker.sv
// port-level checks on the timed command queue, bound to the top level
// depends on tcq_pkg and timed_command_queue_unit
`default_nettype none
module tcq_checker #(
    parameter int DEPTH = tcq_pkg::DEF_DEPTH
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       rsp_valid,
    input wire logic                       rsp_ready,
    input wire logic                       found,
    input wire logic [tcq_pkg::CMD_W-1:0]  out_command,
    input wire logic [tcq_pkg::DATA_W-1:0] out_payload,
    input wire logic [tcq_pkg::TEXT_W-1:0] out_text_ref,
    input wire logic                       overflow,
    input wire logic [tcq_pkg::QCNT_W-1:0] queue_count
);
    import tcq_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !found |-> (out_command == '0) && (out_payload == '0) &&
        (out_text_ref == '0))
        else $error("fields nonzero without found");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !(found && overflow))
        else $error("found and overflow together");

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && (DEPTH < 32) |-> (32'(queue_count) <= 32'(DEPTH)))
        else $error("queue count above depth");
endmodule

bind timed_command_queue_unit tcq_checker #(.DEPTH(DEPTH)) u_tcq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .rsp_valid    (o_rsp.valid),
    .rsp_ready    (o_rsp.ready),
    .found        (o_rsp.found),
    .out_command  (o_rsp.out_command),
    .out_payload  (o_rsp.out_payload),
    .out_text_ref (o_rsp.out_text_ref),
    .overflow     (o_rsp.overflow),
    .queue_count  (o_rsp.queue_count)
);
`default_nettype wire

// File: tb/sv/timed_command_queue_unit_test.sv
// testbench for timed_command_queue_unit: random and directed requests checked
// against an in-bench queue predictor; depends on tcq_pkg, tcq_if and the design
`timescale 1ns / 1ps
`default_nettype none

module timed_command_queue_unit_test;
    import tcq_pkg::*;

    localparam int NCL = DEF_CLIENTS;
    localparam int NDP = DEF_DEPTH;

    typedef struct packed {
        logic              found;
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] payload;
        logic [TEXT_W-1:0] text;
        logic              kicked;
        logic [QCNT_W-1:0] count;
        logic              overflow;
    } t_reply;

    // queue state mirror plus the expected replies in order
    class queue_scoreboard;
        t_entry            slots [NCL][NDP];
        int                cnt   [NCL];
        bit                kick  [NCL];
        logic [LIMIT_W-1:0] limit;
        t_reply            pending [$];
        int                errors;

        function void restart();
            foreach (cnt[c]) begin
                cnt[c] = 0;
                kick[c] = 0;
            end
            limit = LIMIT_RESET;
            pending.delete();
            errors = 0;
        endfunction

        // apply one accepted request and queue its reply
        function void note_request(t_op op, int c, logic [CMD_W-1:0] cmd,
                                   logic [TIME_W-1:0] dly, logic [DATA_W-1:0] dat,
                                   logic [TEXT_W-1:0] txt, logic [TIME_W-1:0] tnow);
            t_reply r;
            logic [TIME_W:0] sum;
            int i;
            int k;
            r = '0;
            case (op)
                OP_ADD: begin
                    if (cnt[c] >= NDP) begin
                        r.overflow = 1'b1;
                    end else begin
                        sum = {1'b0, tnow} + {1'b0, dly};
                        slots[c][cnt[c]].command  = cmd;
                        slots[c][cnt[c]].deadline = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                        slots[c][cnt[c]].payload  = dat;
                        slots[c][cnt[c]].text     = txt;
                        cnt[c]++;
                        if (cnt[c] >= limit) kick[c] = 1'b1;
                    end
                end
                OP_FETCH: begin
                    for (i = 0; i < cnt[c]; i++) begin
                        if (slots[c][i].deadline < tnow) begin
                            r.found   = 1'b1;
                            r.command = slots[c][i].command;
                            r.payload = slots[c][i].payload;
                            r.text    = slots[c][i].text;
                            for (k = i; k + 1 < cnt[c]; k++) slots[c][k] = slots[c][k+1];
                            cnt[c]--;
                            break;
                        end
                    end
                end
                OP_REMOVE: begin
                    i = 0;
                    while (i < cnt[c]) begin
                        if (slots[c][i].command == cmd) begin
                            for (k = i; k + 1 < cnt[c]; k++) slots[c][k] = slots[c][k+1];
                            cnt[c]--;
                        end else begin
                            i++;
                        end
                    end
                end
                default: cnt[c] = 0;
            endcase
            r.kicked = kick[c];
            r.count  = cnt[c][QCNT_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_reply(t_reply got);
            t_reply exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected reply %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.found !== exp.found || got.command !== exp.command ||
                got.payload !== exp.payload || got.text !== exp.text ||
                got.kicked !== exp.kicked || got.count !== exp.count ||
                got.overflow !== exp.overflow) begin
                $display("%0t: reply mismatch expected %h actual %h", $time, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wdata = '0;

    tcq_req_if req ();
    tcq_rsp_if rsp ();

    timed_command_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req.sink),
        .o_rsp       (rsp.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    queue_scoreboard board = new();
    int send_idle_pct;
    int recv_idle_pct;
    logic [TIME_W-1:0] clock_now;

    initial begin
        req.valid = 1'b0;
        req.op = '0;
        req.client = '0;
        req.command = '0;
        req.delay = '0;
        req.payload = '0;
        req.text_ref = '0;
        req.now = '0;
        rsp.ready = 1'b0;
    end

    // receiver: random back-pressure, replies checked at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready)
            board.check_reply({rsp.found, rsp.out_command, rsp.out_payload,
                               rsp.out_text_ref, rsp.kicked, rsp.queue_count,
                               rsp.overflow});
        rsp.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // one request: optional idle gap, then hold valid until accepted
    task automatic send_request(t_op op, int c, logic [CMD_W-1:0] cmd,
                                logic [TIME_W-1:0] dly, logic [DATA_W-1:0] dat,
                                logic [TEXT_W-1:0] txt, logic [TIME_W-1:0] tnow);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        req.valid    <= 1'b1;
        req.op       <= op;
        req.client   <= c[CLIENT_W-1:0];
        req.command  <= cmd;
        req.delay    <= dly;
        req.payload  <= dat;
        req.text_ref <= txt;
        req.now      <= tnow;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        board.note_request(op, c, cmd, dly, dat, txt, tnow);
        req.valid <= 1'b0;
        // the block is busy for at least this cycle after an accept
        @(posedge i_clk);
    endtask

    // wait for all replies, then let the block settle
    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.limit = v;
        @(posedge i_clk);
    endtask

    // mostly adds and fetches across all clients, small command set so removes hit
    task automatic random_request();
        int pick;
        t_op op;
        logic [TIME_W-1:0] dly;
        pick = $urandom_range(99);
        op = pick < 50 ? OP_ADD : pick < 85 ? OP_FETCH : pick < 96 ? OP_REMOVE : OP_CLEAR;
        clock_now += $urandom_range(40);
        if ($urandom_range(49) == 0) clock_now = $urandom();
        pick = $urandom_range(9);
        dly = pick == 0 ? $urandom() : pick == 1 ? 32'hFFFF_FFFF : $urandom_range(60);
        send_request(op, $urandom_range(NCL - 1),
                     CMD_W'($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(3)),
                     dly, $urandom(), TEXT_W'($urandom()), clock_now);
    endtask

    initial begin
        int n;
        board.restart();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        clock_now = 1000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill client 0 past full with extreme fields, kicked at default limit
        for (n = 0; n < NDP + 1; n++)
            send_request(OP_ADD, 0, n[0] ? 8'hFF : 8'h00, n == 0 ? 32'hFFFF_FFFF : 0,
                         n[0] ? 32'hFFFF_FFFF : 32'h0, n[0] ? 16'hFFFF : 16'h0,
                         n == 0 ? 32'hFFFF_FFFF : 32'd5);
        send_request(OP_FETCH, 0, 0, 0, 0, 0, 32'd5);
        send_request(OP_FETCH, 0, 0, 0, 0, 0, 32'd6);
        send_request(OP_FETCH, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 0, 8'hFF, 0, 0, 0, 0);
        send_request(OP_REMOVE, 0, 8'h00, 0, 0, 0, 0);
        send_request(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        send_request(OP_FETCH, 7, 0, 0, 0, 0, 32'hFFFF_FFFF);

        write_limit(5'd0);
        send_request(OP_ADD, 1, 8'h12, 32'd0, 32'h5, 16'h1, 32'd0);
        write_limit(5'd31);
        send_request(OP_ADD, 2, 8'h12, 32'd0, 32'h5, 16'h1, 32'd0);

        // random phases with changing idle mix and limit
        for (n = 0; n < 1100; n++) begin
            if (n == 0) begin
                send_idle_pct = 13;
                recv_idle_pct = 49;
                write_limit(5'd1);
            end
            if (n == 370) begin
                send_idle_pct = 49;
                recv_idle_pct = 13;
                write_limit(5'd8);
            end
            if (n == 740) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                write_limit(5'd16);
            end
            if (n == 550) drain();
            random_request();
        end
        drain();
        if (board.errors == 0)
            $display("timed_command_queue_unit_test: PASS");
        else
            $display("timed_command_queue_unit_test: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("timed_command_queue_unit_test: FAIL");
        $finish;
    end
endmodule

`default_nettype wire
